// ----- sv/dcv_pkg.sv -----
`default_nettype none

package dcv_pkg;

    // Seven chord slots: degrees 1, 3, 5, 7, 9, 11, 13
    localparam int CELLS      = 7;
    localparam int SLOT_W     = $clog2(CELLS);
    localparam int NOTE_W     = 9;
    localparam int FIT_TRIES  = 8;
    localparam int FIT_W      = $clog2(FIT_TRIES + 1);
    localparam int SCALES     = 5;

    typedef logic [NOTE_W-1:0] note_t;

    localparam note_t RANGE_LOW  = note_t'(48);
    localparam note_t RANGE_HIGH = note_t'(84);
    localparam note_t OCTAVE     = note_t'(12);

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SORT_EVEN,
        CELL_SORT_ODD,
        CELL_RAISE,
        CELL_UP,
        CELL_DOWN,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
    } cell_ctrl_t;

    localparam logic [3:0] SCALE_TAB [SCALES][CELLS] = '{
        '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11},
        '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10},
        '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd11},
        '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd9, 4'd10},
        '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd10}
    };

    // Semitone offset of chord slot above the root; slots from the ninth up wrap an octave
    function automatic logic [4:0] degree_offset(input logic [2:0] scale,
                                                 input logic [SLOT_W-1:0] slot);
        logic [2:0] row;
        logic [2:0] step;
        logic [4:0] base;
        row  = (scale < 3'(SCALES)) ? scale : 3'd0;
        step = slot[2] ? {slot[1:0], 1'b1} : {slot[1:0], 1'b0};
        base = {1'b0, SCALE_TAB[row][step]};
        return slot[2] ? base + 5'd12 : base;
    endfunction

endpackage

`default_nettype wire

// ----- sv/dcv_build.sv -----
`default_nettype none

module dcv_build (
    input  wire logic [6:0]  root_note,
    input  wire logic [2:0]  scale_kind,
    input  wire logic [2:0]  quality_level,
    input  wire logic        add_seventh,
    input  wire logic        add_ninth,
    input  wire logic        add_eleventh,
    input  wire logic        add_thirteenth,
    output dcv_pkg::note_t   load_note  [dcv_pkg::CELLS],
    output logic             load_valid [dcv_pkg::CELLS]
);

    always_comb
    begin
        for (int i = 0; i < dcv_pkg::CELLS; i++)
        begin
            load_note[i] = dcv_pkg::note_t'(root_note)
                         + dcv_pkg::note_t'(dcv_pkg::degree_offset(
                               scale_kind, dcv_pkg::SLOT_W'(i)));
        end
        load_valid[0] = 1'b1;
        load_valid[1] = 1'b1;
        load_valid[2] = 1'b1;
        load_valid[3] = (quality_level >= 3'd1) || add_seventh;
        load_valid[4] = (quality_level >= 3'd2) || add_ninth;
        load_valid[5] = (quality_level >= 3'd3) || add_eleventh;
        load_valid[6] = (quality_level >= 3'd4) || add_thirteenth;
    end

endmodule

`default_nettype wire

// ----- sv/dcv_cell.sv -----
`default_nettype none

module dcv_cell #(
    parameter int INDEX = 0
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dcv_pkg::cell_ctrl_t ctrl,
    input  wire dcv_pkg::note_t      load_note,
    input  wire logic                load_valid,
    input  wire dcv_pkg::note_t      left_note,
    input  wire logic                left_valid,
    input  wire dcv_pkg::note_t      right_note,
    input  wire logic                right_valid,
    output dcv_pkg::note_t           note,
    output logic                     valid
);

    localparam bit HAS_RIGHT  = (INDEX < dcv_pkg::CELLS - 1);
    localparam bit EVEN_LEFT  = ((INDEX % 2) == 0) && HAS_RIGHT;
    localparam bit ODD_LEFT   = ((INDEX % 2) == 1) && HAS_RIGHT;
    localparam bit EVEN_RIGHT = ((INDEX % 2) == 1);
    localparam bit ODD_RIGHT  = ((INDEX % 2) == 0) && (INDEX > 0);

    dcv_pkg::note_t note_reg, note_next;
    logic           valid_reg, valid_next;

    // Empty cells sort above every note
    logic [dcv_pkg::NOTE_W:0] self_key, left_key, right_key;
    logic                     take_right, take_left;

    always_comb
    begin
        self_key   = {~valid_reg, note_reg};
        left_key   = {~left_valid, left_note};
        right_key  = {~right_valid, right_note};
        take_right = self_key > right_key;
        take_left  = left_key > self_key;

        note_next  = note_reg;
        valid_next = valid_reg;
        unique case (ctrl.op)
            dcv_pkg::CELL_HOLD:
            begin
            end
            dcv_pkg::CELL_LOAD:
            begin
                note_next  = load_note;
                valid_next = load_valid;
            end
            dcv_pkg::CELL_SORT_EVEN:
            begin
                if ((EVEN_LEFT && take_right))
                begin
                    note_next  = right_note;
                    valid_next = right_valid;
                end
                else if (EVEN_RIGHT && take_left)
                begin
                    note_next  = left_note;
                    valid_next = left_valid;
                end
            end
            dcv_pkg::CELL_SORT_ODD:
            begin
                if ((ODD_LEFT && take_right))
                begin
                    note_next  = right_note;
                    valid_next = right_valid;
                end
                else if (ODD_RIGHT && take_left)
                begin
                    note_next  = left_note;
                    valid_next = left_valid;
                end
            end
            dcv_pkg::CELL_RAISE:
            begin
                if (INDEX == 0)
                begin
                    note_next = note_reg + dcv_pkg::OCTAVE;
                end
            end
            dcv_pkg::CELL_UP:
            begin
                note_next = note_reg + dcv_pkg::OCTAVE;
            end
            dcv_pkg::CELL_DOWN:
            begin
                note_next = note_reg - dcv_pkg::OCTAVE;
            end
            dcv_pkg::CELL_SHIFT:
            begin
                note_next  = right_note;
                valid_next = right_valid;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        note_reg <= note_next;
    end

    assign note  = note_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire

// ----- sv/dcv_ctrl.sv -----
`default_nettype none

module dcv_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic [2:0]           inversion_count,
    input  wire logic                 load_valid [dcv_pkg::CELLS],
    input  wire dcv_pkg::note_t       cell_note  [dcv_pkg::CELLS],
    input  wire logic                 cell_valid [dcv_pkg::CELLS],
    input  wire logic                 out_ready,
    output logic                      in_ready,
    output logic                      out_valid,
    output logic                      last_note,
    output dcv_pkg::cell_ctrl_t       ctrl
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SORT,
        ST_RAISE,
        ST_FIT,
        ST_OUT
    } state_t;

    state_t                      state_reg, state_next;
    logic [dcv_pkg::SLOT_W-1:0]  pass_reg, pass_next;
    logic [2:0]                  inv_reg, inv_next;
    logic [dcv_pkg::FIT_W-1:0]   fit_reg, fit_next;
    logic [2:0]                  cnt_reg, cnt_next;

    logic [2:0]                  count;
    logic [2:0]                  tail_idx;
    dcv_pkg::note_t              head, tail;

    always_comb
    begin
        count = 3'd0;
        for (int i = 0; i < dcv_pkg::CELLS; i++)
        begin
            count = count + {2'b00, load_valid[i]};
        end
    end

    assign tail_idx  = cnt_reg - 3'd1;
    assign head      = cell_note[0];
    assign tail      = cell_note[tail_idx];
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign last_note = !cell_valid[1];

    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        inv_next   = inv_reg;
        fit_next   = fit_reg;
        cnt_next   = cnt_reg;
        ctrl.op    = dcv_pkg::CELL_HOLD;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.op    = dcv_pkg::CELL_LOAD;
                    cnt_next   = count;
                    inv_next   = (inversion_count > count - 3'd1) ? count - 3'd1
                                                                  : inversion_count;
                    pass_next  = '0;
                    fit_next   = '0;
                    state_next = ST_SORT;
                end
            end
            ST_SORT:
            begin
                ctrl.op = pass_reg[0] ? dcv_pkg::CELL_SORT_ODD : dcv_pkg::CELL_SORT_EVEN;
                if (pass_reg == dcv_pkg::SLOT_W'(dcv_pkg::CELLS - 1))
                begin
                    pass_next  = '0;
                    state_next = (inv_reg != 3'd0) ? ST_RAISE : ST_FIT;
                end
                else
                begin
                    pass_next = pass_reg + 1'b1;
                end
            end
            ST_RAISE:
            begin
                ctrl.op    = dcv_pkg::CELL_RAISE;
                inv_next   = inv_reg - 3'd1;
                state_next = ST_SORT;
            end
            ST_FIT:
            begin
                if ((fit_reg == dcv_pkg::FIT_W'(dcv_pkg::FIT_TRIES))
                    || ((head >= dcv_pkg::RANGE_LOW) && (tail <= dcv_pkg::RANGE_HIGH)))
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    ctrl.op  = (head < dcv_pkg::RANGE_LOW) ? dcv_pkg::CELL_UP
                                                           : dcv_pkg::CELL_DOWN;
                    fit_next = fit_reg + 1'b1;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    ctrl.op = dcv_pkg::CELL_SHIFT;
                    if (last_note)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pass_reg  <= '0;
            inv_reg   <= '0;
            fit_reg   <= '0;
            cnt_reg   <= 3'd3;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            inv_reg   <= inv_next;
            fit_reg   <= fit_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("new request taken while a chord is in progress");

    a_chain_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !cell_valid[0])
        else $error("cell chain not empty when idle");

    a_head_valid_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cell_valid[0])
        else $error("word offered from an empty cell");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_note) |=> in_ready)
        else $error("not idle after final note");

    a_fit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fit_reg <= dcv_pkg::FIT_W'(dcv_pkg::FIT_TRIES))
        else $error("octave fitting ran past its limit");

endmodule

`default_nettype wire

// ----- sv/diatonic_chord_voicer_top.sv -----
`default_nettype none

// Diatonic chord voicer: one request word in, three to seven note words out.
// First note is offered after the load, a seven-pass odd-even sort of the cell chain,
// I inversions (each raises the lowest note an octave, then sorts) and F octave shifts;
// I is the applied inversion count (0..6), F the octave shifts made (0..8). Notes then
// leave one a cycle while out_ready is high. One request is worked at a time.
// Reset (rst_n, asynchronous, active low) empties the chain and returns to idle.
module diatonic_chord_voicer_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [6:0] root_note,
    input  wire logic [2:0] scale_kind,
    input  wire logic [2:0] quality_level,
    input  wire logic [2:0] inversion_count,
    input  wire logic       add_seventh,
    input  wire logic       add_ninth,
    input  wire logic       add_eleventh,
    input  wire logic       add_thirteenth,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [6:0]      chord_note,
    output logic            last_note
);

    dcv_pkg::note_t      load_note  [dcv_pkg::CELLS];
    logic                load_valid [dcv_pkg::CELLS];
    dcv_pkg::note_t      cell_note  [dcv_pkg::CELLS];
    logic                cell_valid [dcv_pkg::CELLS];
    dcv_pkg::cell_ctrl_t ctrl;

    // Stack the thirds: one slot per degree, unused extensions marked empty
    dcv_build u_build (
        .root_note      (root_note),
        .scale_kind     (scale_kind),
        .quality_level  (quality_level),
        .add_seventh    (add_seventh),
        .add_ninth      (add_ninth),
        .add_eleventh   (add_eleventh),
        .add_thirteenth (add_thirteenth),
        .load_note      (load_note),
        .load_valid     (load_valid)
    );

    // Sequence load, sort passes, inversions, octave fitting and drain
    dcv_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .inversion_count (inversion_count),
        .load_valid      (load_valid),
        .cell_note       (cell_note),
        .cell_valid      (cell_valid),
        .out_ready       (out_ready),
        .in_ready        (in_ready),
        .out_valid       (out_valid),
        .last_note       (last_note),
        .ctrl            (ctrl)
    );

    // The chain: each cell trades with its neighbours on sort passes, and on
    // drain every cell takes its right neighbour so the lowest note leaves first.
    for (genvar g = 0; g < dcv_pkg::CELLS; g++)
    begin : g_cell
        dcv_pkg::note_t l_note, r_note;
        logic           l_valid, r_valid;

        if (g == 0)
        begin : g_head
            assign l_note  = '0;
            assign l_valid = 1'b0;
        end
        else
        begin : g_mid_l
            assign l_note  = cell_note[g-1];
            assign l_valid = cell_valid[g-1];
        end

        if (g == dcv_pkg::CELLS - 1)
        begin : g_tail
            // Feed an empty slot into the end of the chain on drain
            assign r_note  = '0;
            assign r_valid = 1'b0;
        end
        else
        begin : g_mid_r
            assign r_note  = cell_note[g+1];
            assign r_valid = cell_valid[g+1];
        end

        dcv_cell #(
            .INDEX (g)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .load_note   (load_note[g]),
            .load_valid  (load_valid[g]),
            .left_note   (l_note),
            .left_valid  (l_valid),
            .right_note  (r_note),
            .right_valid (r_valid),
            .note        (cell_note[g]),
            .valid       (cell_valid[g])
        );
    end

    // Head cell is the output register; drop the octave guard bits
    assign chord_note = cell_note[0][6:0];

endmodule

`default_nettype wire

// ----- tb/chord_note_checker.sv -----
`timescale 1ns / 100ps

// Watches both channels, voices each accepted request and compares every note word.
module chord_note_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_ready,
    input  wire logic [6:0] root_note,
    input  wire logic [2:0] scale_kind,
    input  wire logic [2:0] quality_level,
    input  wire logic [2:0] inversion_count,
    input  wire logic       add_seventh,
    input  wire logic       add_ninth,
    input  wire logic       add_eleventh,
    input  wire logic       add_thirteenth,
    input  wire logic       out_valid,
    input  wire logic       out_ready,
    input  wire logic [6:0] chord_note,
    input  wire logic       last_note,
    output int              mismatches,
    output int              notes_due
);

    localparam int SCALE_COUNT = 5;
    localparam int QUALITY_SEVENTH    = 1;
    localparam int QUALITY_NINTH      = 2;
    localparam int QUALITY_ELEVENTH   = 3;
    localparam int QUALITY_THIRTEENTH = 4;
    localparam int FIT_LOW   = 48;
    localparam int FIT_HIGH  = 84;
    localparam int SEMITONES = 12;
    localparam int FIT_LIMIT = 8;

    localparam int SCALE_STEPS [SCALE_COUNT][7] = '{
        '{0, 2, 4, 5, 7, 9, 11},
        '{0, 2, 3, 5, 7, 8, 10},
        '{0, 2, 3, 5, 7, 8, 11},
        '{0, 2, 3, 5, 7, 9, 10},
        '{0, 2, 4, 5, 7, 9, 10}
    };

    logic [6:0] voiced_notes [$];
    logic       voiced_last  [$];

    int chord_buf [7];
    int chord_size;

    initial
    begin
        mismatches = 0;
        notes_due  = 0;
    end

    task automatic report_mismatch(input string msg);
    begin
        $display("%0t ns mismatch: %s", $time, msg);
        mismatches++;
    end
    endtask

    // Insertion sort of the working chord, lowest note first
    function automatic void sort_chord();
        int v;
        int j;
        for (int i = 1; i < chord_size; i++)
        begin
            v = chord_buf[i];
            j = i - 1;
            while (j >= 0 && chord_buf[j] > v)
            begin
                chord_buf[j + 1] = chord_buf[j];
                j--;
            end
            chord_buf[j + 1] = v;
        end
    endfunction

    task automatic voice_chord(input logic [6:0] root, input logic [2:0] scale,
                               input logic [2:0] quality, input logic [2:0] inversions,
                               input logic [3:0] adds);
        int degrees [7];
        int row;
        int lift;
        int lo;
        int hi;
        int shift;
        int k;
        bit fitted;
    begin
        row = (int'(scale) < SCALE_COUNT) ? int'(scale) : 0;
        degrees[0] = 1;
        degrees[1] = 3;
        degrees[2] = 5;
        chord_size = 3;
        if (int'(quality) >= QUALITY_SEVENTH || adds[0])
        begin
            degrees[chord_size] = 7;
            chord_size++;
        end
        if (int'(quality) >= QUALITY_NINTH || adds[1])
        begin
            degrees[chord_size] = 9;
            chord_size++;
        end
        if (int'(quality) >= QUALITY_ELEVENTH || adds[2])
        begin
            degrees[chord_size] = 11;
            chord_size++;
        end
        if (int'(quality) >= QUALITY_THIRTEENTH || adds[3])
        begin
            degrees[chord_size] = 13;
            chord_size++;
        end

        for (int i = 0; i < chord_size; i++)
        begin
            k = degrees[i] - 1;
            chord_buf[i] = int'(root) + SCALE_STEPS[row][k % 7] + (k / 7) * SEMITONES;
        end

        // Clamp inversions to one fewer than the note count
        lift = int'(inversions);
        if (lift > chord_size - 1)
            lift = chord_size - 1;
        for (int t = 0; t < lift; t++)
        begin
            sort_chord();
            chord_buf[0] += SEMITONES;
        end

        // Octave fitting, bounded number of tries
        fitted = 1'b0;
        for (int t = 0; t < FIT_LIMIT && !fitted; t++)
        begin
            lo = chord_buf[0];
            hi = chord_buf[0];
            for (int i = 1; i < chord_size; i++)
            begin
                if (chord_buf[i] < lo) lo = chord_buf[i];
                if (chord_buf[i] > hi) hi = chord_buf[i];
            end
            if (lo < FIT_LOW)
                shift = SEMITONES;
            else if (hi > FIT_HIGH)
                shift = -SEMITONES;
            else
                fitted = 1'b1;
            if (!fitted)
                for (int i = 0; i < chord_size; i++)
                    chord_buf[i] += shift;
        end

        sort_chord();
        for (int i = 0; i < chord_size; i++)
        begin
            voiced_notes = {voiced_notes, 7'(chord_buf[i])};
            voiced_last  = {voiced_last, (i == chord_size - 1)};
        end
    end
    endtask

    always @(posedge clk)
    begin
        logic [6:0] want_note;
        logic       want_last;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                voice_chord(root_note, scale_kind, quality_level, inversion_count,
                            {add_thirteenth, add_eleventh, add_ninth, add_seventh});
            if (out_valid && out_ready)
            begin
                if (voiced_notes.size() == 0)
                    report_mismatch($sformatf("unexpected note word %0d last %0b",
                                              chord_note, last_note));
                else
                begin
                    want_note = voiced_notes.pop_front();
                    want_last = voiced_last.pop_front();
                    if (chord_note !== want_note)
                        report_mismatch($sformatf("chord_note got %0d expected %0d",
                                                  chord_note, want_note));
                    if (last_note !== want_last)
                        report_mismatch($sformatf("last_note got %0b expected %0b on note %0d",
                                                  last_note, want_last, want_note));
                end
            end
            notes_due = voiced_notes.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

// Stimulus and verdict for the chord voicer. Prediction and comparison live in
// the checker beside the block; this module only makes request words, paces
// the result side and decides the outcome.
module tb_top;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [6:0] root_note;
    logic [2:0] scale_kind;
    logic [2:0] quality_level;
    logic [2:0] inversion_count;
    logic       add_seventh;
    logic       add_ninth;
    logic       add_eleventh;
    logic       add_thirteenth;
    logic       out_valid;
    logic       out_ready;
    logic [6:0] chord_note;
    logic       last_note;

    int mismatches;
    int notes_due;

    // Set for the closing stretch: both sides run flat out
    bit quiet;

    localparam int RANDOM_WORDS = 77;
    localparam int QUIET_WORDS  = 20;
    // Held after the final drain; comfortable margin over the slowest request
    localparam int DRAIN_CYCLES = 80;

    always #2 clk = ~clk;

    diatonic_chord_voicer_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .root_note       (root_note),
        .scale_kind      (scale_kind),
        .quality_level   (quality_level),
        .inversion_count (inversion_count),
        .add_seventh     (add_seventh),
        .add_ninth       (add_ninth),
        .add_eleventh    (add_eleventh),
        .add_thirteenth  (add_thirteenth),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .chord_note      (chord_note),
        .last_note       (last_note)
    );

    chord_note_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .root_note       (root_note),
        .scale_kind      (scale_kind),
        .quality_level   (quality_level),
        .inversion_count (inversion_count),
        .add_seventh     (add_seventh),
        .add_ninth       (add_ninth),
        .add_eleventh    (add_eleventh),
        .add_thirteenth  (add_thirteenth),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .chord_note      (chord_note),
        .last_note       (last_note),
        .mismatches      (mismatches),
        .notes_due       (notes_due)
    );

    // Offer one request word and hold it until taken. Called at a rising edge;
    // returns at the edge where the word is accepted. A random gap with valid
    // dropped may come first, except in the quiet stretch.
    task automatic send_chord(input logic [6:0] root, input logic [2:0] scale,
                              input logic [2:0] quality, input logic [2:0] inversions,
                              input logic [3:0] adds);
    begin
        if (!quiet && $urandom_range(0, 2) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid        <= 1'b1;
        root_note       <= root;
        scale_kind      <= scale;
        quality_level   <= quality;
        inversion_count <= inversions;
        add_seventh     <= adds[0];
        add_ninth       <= adds[1];
        add_eleventh    <= adds[2];
        add_thirteenth  <= adds[3];
        // Advance until the block samples valid with ready high
        do
            @(posedge clk);
        while (!in_ready);
    end
    endtask

    // Drop valid and hold until every predicted note has been taken. The first
    // edge lets the checker record the word accepted at the edge we came from.
    task automatic drain_notes();
    begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (notes_due != 0)
            @(posedge clk);
    end
    endtask

    // Result side: ready in random bursts, mostly high, with random stalls;
    // flat out once the quiet stretch begins
    initial
    begin
        int burst;
        out_ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (quiet)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                burst = $urandom_range(1, 18);
                out_ready <= ($urandom_range(0, 2) != 0);
                repeat (burst) @(posedge clk);
            end
        end
    end

    initial
    begin
        quiet           = 1'b0;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        root_note       = '0;
        scale_kind      = '0;
        quality_level   = '0;
        inversion_count = '0;
        add_seventh     = 1'b0;
        add_ninth       = 1'b0;
        add_eleventh    = 1'b0;
        add_thirteenth  = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes: lowest root, plain triad, fitted up by several octaves
        send_chord(7'd0, 3'd0, 3'd0, 3'd0, 4'h0);
        // Every field at its top: unknown scale, quality above thirteenth,
        // inversions beyond the note count, all add flags, fitted down
        send_chord(7'd127, 3'd7, 3'd7, 3'd7, 4'hF);

        // Every scale kind, each with its own quality and inversion request;
        // covers the unknown scales and a clamped inversion on a full thirteenth
        for (int s = 0; s < 8; s++)
            send_chord(7'd60, 3'(s), 3'(s), 3'(s), 4'h0);

        // Each add flag on its own over a triad
        for (int f = 0; f < 4; f++)
            send_chord(7'(55 + 4 * f), 3'(f), 3'd0, 3'(f), 4'(1 << f));

        // All add flags over a triad level
        send_chord(7'd72, 3'd1, 3'd0, 3'd2, 4'hF);

        // Full thirteenth through every inversion count
        for (int v = 0; v < 8; v++)
            send_chord(7'd40, 3'd2, 3'd4, 3'(v), 4'h0);

        // Random requests; pause once midway until the notes are all out,
        // and run the closing stretch with no idling on either side
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == RANDOM_WORDS / 2)
                drain_notes();
            if (n == RANDOM_WORDS - QUIET_WORDS)
                quiet = 1'b1;
            send_chord(7'($urandom_range(0, 127)), 3'($urandom_range(0, 7)),
                       3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                       4'($urandom_range(0, 15)));
        end

        drain_notes();
        // Hold a little longer to catch any stray note word
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("PASS diatonic_chord_voicer_top");
        else
            $display("FAIL diatonic_chord_voicer_top");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #2000000;
        $display("FAIL diatonic_chord_voicer_top");
        $finish;
    end

endmodule
